// File: src/smc_pkg.sv
// Shared constants and types for the sliding-window median filter.
// No dependencies; imported by every other file of the block.
package smc_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int CFG_W      = 7;
	localparam int SAMPLE_W   = 32;
	localparam int MEDIAN_W   = 33;
	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 1;
	localparam int M_TDATA_W  = 40;

	// Broadcast from the control logic to every cell of the sorted chain.
	typedef struct packed {
		logic upd;      // cells take their next contents this cycle
		logic ins;      // a sample is being inserted
		logic restart;  // every stored entry is invalidated before insertion
	} smc_ctrl_t;

endpackage

// File: src/sliding_window_median_top.sv
// Top level of the sliding-window median filter: sorted cell chain, fill count and output stages.
// Depends on smc_pkg and smc_cell.
//
//  channel   | direction | contents
//  ----------+-----------+---------------------------------------------------
//  cfg       | in        | cfg_wdata = window_size, written when cfg_wen is high
//  s_axis    | in        | s_tdata = sample, s_tuser = restart
//  m_axis    | out       | m_tdata = median_twice (33 bits, zero padded to 40)
//
// One sample is accepted per cycle while the output side keeps up and no stale entry is being removed;
// a result reaches m_tvalid through the chain, the tap stage and the sum.
// After window_size is lowered, each stored entry that falls outside the new window is
// removed in a cycle of its own, with s_tready low, before the next sample is taken.
// Reset clears the valid bit of every cell and the fill count and sets window_size to 1.
// An output stall holds the result; s_tready drops only once the tap stage is also full.
module sliding_window_median_top import smc_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_W-1:0]     cfg_wdata,   // window_size
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,     // [31:0] sample
	input  logic [S_TUSER_W-1:0] s_tuser,     // [0] restart
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata      // [32:0] median_twice, [39:33] zero
);

	localparam int VW = SAMPLE_BITS;
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int WW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0]     win_size_q;
	logic [WW-1:0]        win_x;
	logic [CW-1:0]        w_eff;
	logic [CW-1:0]        lo_idx;
	logic [CW-1:0]        hi_idx;
	logic [WINDOW_MAX-1:0] tap_lo_q;
	logic [WINDOW_MAX-1:0] tap_hi_q;

	logic                 accept;
	logic                 purge;
	logic                 del_any;
	smc_ctrl_t            ctrl;
	logic signed [VW-1:0] smp;

	logic signed [VW-1:0] val_a    [WINDOW_MAX];
	logic                 vld_a    [WINDOW_MAX];
	logic [AW-1:0]        age_a    [WINDOW_MAX];
	logic signed [VW-1:0] sh_val_a [WINDOW_MAX];
	logic                 sh_vld_a [WINDOW_MAX];
	logic [AW-1:0]        sh_age_a [WINDOW_MAX];
	logic                 lt_a     [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] stale_v;
	logic [WINDOW_MAX-1:0] drop_v;
	logic [WINDOW_MAX-1:0] del_v;
	logic [WINDOW_MAX-1:0] shl_v;

	logic [CW-1:0]        fill_q;
	logic [CW-1:0]        fill_n;
	logic                 emit_n;
	logic                 emit_q;

	logic                 med_vld_s1;
	logic signed [VW-1:0] med_lo_s1;
	logic signed [VW-1:0] med_hi_s1;
	logic signed [VW-1:0] lo_sel;
	logic signed [VW-1:0] hi_sel;
	logic                 s1_free;
	logic                 out_adv;
	logic                 out_vld_q;
	logic [MEDIAN_W-1:0]  twice_q;
	logic [MEDIAN_W-1:0]  lo_x;
	logic [MEDIAN_W-1:0]  hi_x;

	// Effective window: zero counts as one, anything above the chain length saturates.
	always_comb begin
		win_x = WW'(win_size_q);
		if (win_x == '0) begin
			w_eff = CW'(1);
		end else if (win_x > WW'(WINDOW_MAX)) begin
			w_eff = CW'(WINDOW_MAX);
		end else begin
			w_eff = CW'(win_x);
		end
		hi_idx = w_eff >> 1;
		lo_idx = w_eff[0] ? hi_idx : (hi_idx - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= CFG_W'(1);
		end else if (cfg_wen) begin
			win_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			tap_lo_q[i] <= (lo_idx == CW'(i));
			tap_hi_q[i] <= (hi_idx == CW'(i));
		end
	end

	assign smp      = s_tdata[VW-1:0];
	assign purge    = |stale_v;
	assign s1_free  = !med_vld_s1 || out_adv;
	assign s_tready = !purge && !(emit_q && !s1_free);
	assign accept   = s_tvalid && s_tready;
	assign del_any  = |drop_v;
	assign del_v    = purge ? stale_v : drop_v;

	always_comb begin
		ctrl.upd     = accept || purge;
		ctrl.ins     = accept;
		ctrl.restart = accept && s_tuser[0];
	end

	genvar g;
	generate
		for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
			logic signed [VW-1:0] nv;
			logic                 nvld;
			logic [AW-1:0]        nage;
			logic signed [VW-1:0] pv;
			logic                 pvld;
			logic [AW-1:0]        page;
			logic                 plt;

			assign shl_v[g] = |del_v[g:0];

			if (g == WINDOW_MAX - 1) begin : g_top
				assign nv   = '0;
				assign nvld = 1'b0;
				assign nage = '0;
			end else begin : g_mid
				assign nv   = val_a[g+1];
				assign nvld = vld_a[g+1];
				assign nage = age_a[g+1];
			end

			if (g == 0) begin : g_bot
				assign pv   = '0;
				assign pvld = 1'b0;
				assign page = '0;
				assign plt  = 1'b0;
			end else begin : g_up
				assign pv   = sh_val_a[g-1];
				assign pvld = sh_vld_a[g-1];
				assign page = sh_age_a[g-1];
				assign plt  = lt_a[g-1];
			end

			smc_cell #(
				.VW(VW),
				.AW(AW),
				.CW(CW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.win       (w_eff),
				.smp       (smp),
				.shift_sel (shl_v[g]),
				.nxt_val   (nv),
				.nxt_vld   (nvld),
				.nxt_age   (nage),
				.prv_val   (pv),
				.prv_vld   (pvld),
				.prv_age   (page),
				.prv_lt    (plt),
				.val       (val_a[g]),
				.vld       (vld_a[g]),
				.age       (age_a[g]),
				.sh_val    (sh_val_a[g]),
				.sh_vld    (sh_vld_a[g]),
				.sh_age    (sh_age_a[g]),
				.lt        (lt_a[g]),
				.stale     (stale_v[g]),
				.drop      (drop_v[g])
			);
		end
	endgenerate

	// Fill count follows the chain: restart leaves only the new sample.
	always_comb begin
		fill_n = fill_q;
		if (accept) begin
			if (s_tuser[0]) begin
				fill_n = CW'(1);
			end else begin
				fill_n = fill_q - CW'(del_any) + CW'(1);
			end
		end else if (purge) begin
			fill_n = fill_q - CW'(1);
		end
		emit_n = (fill_n == w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			emit_q <= 1'b0;
		end else begin
			fill_q <= fill_n;
			if (accept) begin
				emit_q <= emit_n;
			end else if (s1_free) begin
				emit_q <= 1'b0;
			end
		end
	end

	always_comb begin
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			lo_sel = lo_sel | (tap_lo_q[i] ? val_a[i] : '0);
			hi_sel = hi_sel | (tap_hi_q[i] ? val_a[i] : '0);
		end
	end

	assign out_adv = med_vld_s1 && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_vld_s1 <= 1'b0;
		end else if (emit_q && s1_free) begin
			med_vld_s1 <= 1'b1;
		end else if (out_adv) begin
			med_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q && s1_free) begin
			med_lo_s1 <= lo_sel;
			med_hi_s1 <= hi_sel;
		end
	end

	assign lo_x = {{(MEDIAN_W-VW){med_lo_s1[VW-1]}}, med_lo_s1};
	assign hi_x = {{(MEDIAN_W-VW){med_hi_s1[VW-1]}}, med_hi_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			twice_q <= lo_x + hi_x;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(M_TDATA_W-MEDIAN_W){1'b0}}, twice_q};

endmodule

// File: src/smc_cell.sv
// One cell of the sorted sample chain: value, age and valid bit of one rank.
// Depends on smc_pkg for the control struct.
module smc_cell import smc_pkg::*; #(
	parameter int VW = SAMPLE_BITS_DEF,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smc_ctrl_t            ctrl,
	input  logic [CW-1:0]        win,
	input  logic signed [VW-1:0] smp,
	input  logic                 shift_sel,
	input  logic signed [VW-1:0] nxt_val,
	input  logic                 nxt_vld,
	input  logic [AW-1:0]        nxt_age,
	input  logic signed [VW-1:0] prv_val,
	input  logic                 prv_vld,
	input  logic [AW-1:0]        prv_age,
	input  logic                 prv_lt,
	output logic signed [VW-1:0] val,
	output logic                 vld,
	output logic [AW-1:0]        age,
	output logic signed [VW-1:0] sh_val,
	output logic                 sh_vld,
	output logic [AW-1:0]        sh_age,
	output logic                 lt,
	output logic                 stale,
	output logic                 drop
);

	logic signed [VW-1:0] val_q;
	logic                 vld_q;
	logic [AW-1:0]        age_q;
	logic signed [VW-1:0] val_n;
	logic                 vld_n;
	logic [AW-1:0]        age_n;
	logic [CW-1:0]        age_x;

	assign val = val_q;
	assign vld = vld_q;
	assign age = age_q;

	// Removal of one entry somewhere at or below this rank pulls the upper neighbor down.
	always_comb begin
		sh_val = shift_sel ? nxt_val : val_q;
		sh_vld = (shift_sel ? nxt_vld : vld_q) && !ctrl.restart;
		sh_age = shift_sel ? nxt_age : age_q;
		lt     = !sh_vld || (smp < sh_val);
		age_x  = CW'(age_q);
		stale  = vld_q && (age_x >= win);
		drop   = vld_q && ((age_x + CW'(1)) >= win);
	end

	// Insertion: the first rank whose value exceeds the sample takes it, ranks above move up.
	always_comb begin
		val_n = sh_val;
		vld_n = sh_vld;
		age_n = sh_age;
		if (ctrl.ins) begin
			if (lt && prv_lt) begin
				val_n = prv_val;
				vld_n = prv_vld;
				age_n = prv_age + AW'(1);
			end else if (lt) begin
				val_n = smp;
				vld_n = 1'b1;
				age_n = '0;
			end else begin
				age_n = sh_age + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.upd) begin
			vld_q <= vld_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			val_q <= val_n;
			age_q <= age_n;
		end
	end

endmodule

// File: src/smc_checker.sv
// Port-level checks for the sliding-window median filter, bound to the top level.
// Depends on smc_pkg for port widths.
module smc_checker import smc_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_wen,
	input logic [CFG_W-1:0]     cfg_wdata,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [S_TUSER_W-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic [CFG_W-1:0] win_size_q;
	logic             odd_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= CFG_W'(1);
		end else if (cfg_wen) begin
			win_size_q <= cfg_wdata;
		end
	end

	// An odd window yields twice one element, so the result must be even.
	assign odd_win = (win_size_q == '0) ||
	                 (win_size_q[0] && (int'(win_size_q) <= WINDOW_MAX));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:MEDIAN_W] == '0))
		else $error("padding bits of m_tdata are not zero");

	a_odd_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && odd_win |-> !m_tdata[0])
		else $error("odd window produced an odd doubled median");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result offered during reset");

endmodule

bind sliding_window_median_top smc_checker #(.WINDOW_MAX(WINDOW_MAX)) u_smc_checker (.*);

// File: sim/tb.sv
// Self-checking testbench for the sliding-window median filter top level.
// Needs smc_pkg and the block's RTL. It drives a table of directed samples and then random phases,
// and it checks each result against a window model kept in arrival order or a typed-in median.
module tb import smc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [31:0]         value;    // window size for ROW_CFG, sample otherwise
		logic                restart;
		logic                known;    // median typed in below rather than predicted
		logic [MEDIAN_W-1:0] median;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;     // [31:0] sample
	logic [S_TUSER_W-1:0] s_tuser;     // [0] restart
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;     // [32:0] median_twice, [39:33] zero

	stim_row_t           stim_rows[$];
	logic [MEDIAN_W-1:0] pending_medians[$];
	int                  window_samples[$];   // oldest sample first
	int                  window_cfg;
	int                  errors;
	int                  cycles;
	int                  rx_left;
	bit                  burst_phase;

	sliding_window_median_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int effective_size(input int cfg);
		if (cfg == 0)
			return 1;
		if (cfg > WINDOW_MAX_DEF)
			return WINDOW_MAX_DEF;
		return cfg;
	endfunction

	function automatic logic [MEDIAN_W-1:0] window_median_twice(input int n);
		int     sorted[WINDOW_MAX_DEF];
		int     key;
		int     j;
		longint total;
		for (int i = 0; i < n; i++) begin
			key = window_samples[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		if (n % 2 == 1)
			total = 2 * longint'(sorted[n/2]);
		else
			total = longint'(sorted[n/2-1]) + longint'(sorted[n/2]);
		return total[MEDIAN_W-1:0];
	endfunction

	// Older samples leave until there is room for the new one; a result comes out only
	// when the window is exactly full after the new sample enters.
	function automatic void take_sample(input logic [31:0] smp, input logic rst,
			output bit has, output logic [MEDIAN_W-1:0] med);
		int size;
		size = effective_size(window_cfg);
		if (rst)
			window_samples.delete();
		while (window_samples.size() > size - 1)
			window_samples.delete(0);
		window_samples.insert(window_samples.size(), $signed(smp));
		has = (window_samples.size() == size);
		med = has ? window_median_twice(size) : '0;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (burst_phase)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [31:0] random_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			// A narrow range gives plenty of equal samples.
			1, 2, 3, 4: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [31:0] value, input logic rst,
			input logic known, input logic [MEDIAN_W-1:0] med);
		stim_row_t row;
		row.kind    = kind;
		row.value   = value;
		row.restart = rst;
		row.known   = known;
		row.median  = med;
		stim_rows.insert(stim_rows.size(), row);
	endtask

	task automatic send_sample(input logic [31:0] smp, input logic rst, input logic known,
			input logic [MEDIAN_W-1:0] typed_med);
		int                  gap;
		bit                  has;
		logic [MEDIAN_W-1:0] med;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= rst;
		do @(posedge clk); while (!s_tready);
		take_sample(smp, rst, has, med);
		if (has)
			pending_medians.insert(pending_medians.size(), known ? typed_med : med);
	endtask

	// The window size changes only once every result is out and the chain has settled.
	task automatic write_window(input logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		window_cfg = val;
	endtask

	always @(posedge clk) begin
		int roll;
		if (rx_left > 0) begin
			rx_left <= rx_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				m_tready <= 1'b1;
				rx_left  <= $urandom_range(0, 15);
			end else if (roll < 65) begin
				m_tready <= 1'b1;
				rx_left  <= $urandom_range(40, 120);
			end else if (roll < 93) begin
				m_tready <= 1'b0;
				rx_left  <= $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b0;
				rx_left  <= $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		logic [MEDIAN_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_medians.size() == 0) begin
				$display("%0t: median_twice expected none, got %0d", $time,
					$signed(m_tdata[MEDIAN_W-1:0]));
				errors++;
			end else begin
				want = pending_medians.pop_front();
				if (m_tdata[MEDIAN_W-1:0] !== want) begin
					$display("%0t: median_twice expected %0d, got %0d", $time,
						$signed(want), $signed(m_tdata[MEDIAN_W-1:0]));
					errors++;
				end
				if (m_tdata[M_TDATA_W-1:MEDIAN_W] !== '0) begin
					$display("%0t: tdata padding expected 0, got %h", $time,
						m_tdata[M_TDATA_W-1:MEDIAN_W]);
					errors++;
				end
			end
		end
	end

	initial begin
		int       random_sent;
		int       roll;
		int       phase_len;
		logic [CFG_W-1:0] next_cfg;

		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		m_tready  <= 1'b0;
		rx_left     = 0;
		errors      = 0;
		cycles      = 0;
		window_cfg  = 1;
		burst_phase = 1'b0;
		random_sent = 0;

		// A window of one returns twice each sample.
		add_row(ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE);
		add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000);
		add_row(ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, 33'h0_0000_0000);
		add_row(ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFE);
		add_row(ROW_SAMPLE, 32'h0000_0001, 1'b1, 1'b1, 33'h0_0000_0002);
		// A window size of zero behaves as one.
		add_row(ROW_CFG,    32'd0,         1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'hFFFF_FFFB, 1'b0, 1'b1, 33'h1_FFFF_FFF6);
		// Growing to an even window keeps the stored sample.
		add_row(ROW_CFG,    32'd2,         1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE);
		add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000);
		add_row(ROW_SAMPLE, 32'h0000_0003, 1'b1, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_0009, 1'b0, 1'b0, '0);
		add_row(ROW_CFG,    32'd3,         1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, '0);
		// Oversized setting saturates; then shrinking drops the oldest samples.
		add_row(ROW_CFG,    32'd127,       1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_000B, 1'b1, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h1234_5678, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'hEDCB_A987, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_0005, 1'b0, 1'b0, '0);
		add_row(ROW_CFG,    32'd2,         1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h0000_0064, 1'b0, 1'b0, '0);
		add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				write_window(stim_rows[i].value[CFG_W-1:0]);
			else
				send_sample(stim_rows[i].value, stim_rows[i].restart, stim_rows[i].known,
					stim_rows[i].median);
		end

		// Random phases, each with its own window size and pacing.
		while (random_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				next_cfg = '0;
			else if (roll == 1)
				next_cfg = 7'd127;
			else if (roll == 2)
				next_cfg = 7'd64;
			else if (roll == 3)
				next_cfg = 7'($urandom_range(65, 126));
			else if (roll < 6)
				next_cfg = 7'($urandom_range(9, 63));
			else
				next_cfg = 7'($urandom_range(1, 8));
			write_window(next_cfg);
			burst_phase = ($urandom_range(0, 3) == 0);
			phase_len = effective_size(window_cfg) + $urandom_range(4, 40);
			for (int k = 0; k < phase_len; k++) begin
				send_sample(random_sample(), $urandom_range(0, 29) == 0, 1'b0, '0);
				random_sent++;
			end
		end

		s_tvalid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_medians.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
